@@ hw/rtl/pue_pkg.sv @@
// Shared types, constants and helper functions of the postfix unit expression evaluator.
// Depends on nothing; every other file of the block but pue_checker imports it.
package pue_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int FRAC_BITS   = 16;
    localparam int DATA_W      = 32;
    localparam int REF_W       = 16;
    localparam int RESULT_W    = 16;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CFG_IDX_W   = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PERCENT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_EM      = CFG_IDX_W'(1);

    // Token kinds, units and operators.
    localparam logic       KIND_OPERAND  = 1'b0;
    localparam logic       KIND_OPERATOR = 1'b1;
    localparam logic [1:0] UNIT_PLAIN    = 2'd0;
    localparam logic [1:0] UNIT_PIXEL    = 2'd1;
    localparam logic [1:0] UNIT_PERCENT  = 2'd2;
    localparam logic [1:0] UNIT_EM       = 2'd3;
    localparam logic [1:0] OP_MUL        = 2'd0;
    localparam logic [1:0] OP_ADD        = 2'd1;
    localparam logic [1:0] OP_SUB        = 2'd2;
    localparam logic [1:0] OP_DIV        = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [1:0] ST_DIVZERO   = 2'd3;

    typedef logic signed [DATA_W-1:0]   t_word;
    typedef logic signed [2*DATA_W-1:0] t_wide;

    localparam t_word WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Request from the sequencer to the divider.
    typedef struct packed {
        logic  start;
        t_word dividend;
        t_word divisor;
    } t_div_req;

    // Clamp a wide signed value to the signed word range.
    function automatic t_word sat_word(input t_wide v);
        t_word r;
        if (v > t_wide'(WORD_MAX)) begin
            r = WORD_MAX;
        end else if (v < t_wide'(WORD_MIN)) begin
            r = WORD_MIN;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // Keep the first error of an expression.
    function automatic logic [1:0] keep_first(input logic [1:0] cur, input logic [1:0] code);
        return (cur == ST_OK) ? code : cur;
    endfunction

endpackage

@@ hw/rtl/pue_stack_ram.sv @@
// Value stack storage: one write port and one read port with registered read data.
// Depends on pue_pkg for the depth and word width.
module pue_stack_ram (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [pue_pkg::ADDR_W-1:0] i_wr_addr,
    input  pue_pkg::t_word             i_wr_data,
    input  logic [pue_pkg::ADDR_W-1:0] i_rd_addr,
    output pue_pkg::t_word             o_rd_data
);
    import pue_pkg::*;

    t_word r_mem [STACK_DEPTH];
    t_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/pue_divider.sv @@
// Radix-2 restoring divider for fixed-point quotients, one quotient bit per cycle.
// Depends on pue_pkg for the word type, the fraction width and the request struct.
module pue_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pue_pkg::t_div_req i_req,
    output logic              o_done,
    output pue_pkg::t_word    o_quot
);
    import pue_pkg::*;

    localparam int DVD_W = DATA_W + FRAC_BITS;
    localparam int ITER  = DATA_W;
    localparam int CNT_W = $clog2(ITER);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W:0]   r_rem;
    logic [DATA_W-1:0] r_lo;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_dvs;
    logic              r_neg;
    logic              r_ovf;

    logic [DATA_W-1:0] a_mag;
    logic [DATA_W-1:0] b_mag;
    logic [DVD_W-1:0]  dvd;
    logic [DVD_W-1:0]  dvd_hi;
    logic [DATA_W:0]   rem_sh;
    logic              take;
    logic [DATA_W:0]   n_rem;

    // Operand magnitudes; the most negative word maps onto its unsigned magnitude.
    assign a_mag  = i_req.dividend[DATA_W-1] ? DATA_W'(-i_req.dividend) : i_req.dividend;
    assign b_mag  = i_req.divisor[DATA_W-1]  ? DATA_W'(-i_req.divisor)  : i_req.divisor;
    assign dvd    = DVD_W'(a_mag) << FRAC_BITS;
    assign dvd_hi = dvd >> DATA_W;

    assign rem_sh = {r_rem[DATA_W-1:0], r_lo[DATA_W-1]};
    assign take   = rem_sh >= {1'b0, r_dvs};
    assign n_rem  = take ? (rem_sh - {1'b0, r_dvs}) : rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ITER - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= (DATA_W + 1)'(dvd_hi);
            r_lo  <= dvd[DATA_W-1:0];
            r_quo <= '0;
            r_dvs <= b_mag;
            r_neg <= i_req.dividend[DATA_W-1] ^ i_req.divisor[DATA_W-1];
            // Quotient bits above the word are nonzero when the high part already divides.
            r_ovf <= dvd_hi >= DVD_W'(b_mag);
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_lo  <= r_lo << 1;
            r_quo <= {r_quo[DATA_W-2:0], take};
        end
    end

    always_comb begin
        if (r_ovf) begin
            o_quot = r_neg ? WORD_MIN : WORD_MAX;
        end else if (!r_neg) begin
            o_quot = r_quo[DATA_W-1] ? WORD_MAX : t_word'(r_quo);
        end else if (r_quo > DATA_W'(WORD_MIN)) begin
            o_quot = WORD_MIN;
        end else begin
            o_quot = t_word'(-r_quo);
        end
    end

    assign o_done = r_done;

endmodule

@@ hw/rtl/postfix_unit_expression_evaluator_core.sv @@
// Top level of the postfix unit expression evaluator: sequencer, shared multiplier and adder.
// Depends on pue_pkg, pue_stack_ram and pue_divider.
//
// Usage: tokens of a postfix expression arrive one per transfer on the input channel
// (i_in_valid / o_in_ready). An operand token carries a signed Q16.16 value and a unit;
// percent and em operands are scaled by the references written on the configuration
// channel (i_cfg_valid / o_cfg_ready, index 0 percent, index 1 em), which is always ready.
// An operator token pops two values and pushes product, sum, difference or quotient,
// each saturated to 32 bits. The token marked last produces one transfer on the output
// channel (o_out_valid / i_out_ready): the integer part of the stack top and the first
// error status of the expression, after which the stack is emptied.
// The block handles one token at a time and drops o_in_ready while it works. A plain or
// pixel operand is pushed directly, a scaled operand passes the multiplier and the
// saturation first, an operator reads its two values and computes before its push, and
// a last token also passes the output step. A divide waits on the radix-2 divider, which
// retires one quotient bit per cycle; the stack reads its values through one read port.
// Reset clears the stack pointer, the error status, the references and the output valid
// flag; the stack memory itself is not cleared and needs no clearing pass.
// A result waits in the output register while the receiver stalls; new tokens are still
// taken meanwhile, and only a following last token waits until the register is free.
module postfix_unit_expression_evaluator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pue_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pue_pkg::REF_W-1:0]     i_cfg_data,
    // token channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_kind,
    input  logic [1:0]                    i_unit,
    input  logic [1:0]                    i_op,
    input  pue_pkg::t_word                i_value,
    input  logic                          i_last,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [pue_pkg::RESULT_W-1:0] o_result,
    output logic [1:0]                    o_status
);
    import pue_pkg::*;

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCALE = 4'd1;
    localparam logic [3:0] S_SAT   = 4'd2;
    localparam logic [3:0] S_PUSH  = 4'd3;
    localparam logic [3:0] S_RDB   = 4'd4;
    localparam logic [3:0] S_RDA   = 4'd5;
    localparam logic [3:0] S_OPA   = 4'd6;
    localparam logic [3:0] S_OPER  = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;
    localparam logic [3:0] S_TOP   = 4'd10;

    localparam int IP_W = DATA_W + 1;

    logic [3:0]          r_state;
    logic [SP_W-1:0]     r_sp;
    logic [1:0]          r_err;
    logic [REF_W-1:0]    r_pct_ref;
    logic [REF_W-1:0]    r_em_ref;
    logic                r_out_valid;
    logic signed [RESULT_W-1:0] r_result;
    logic [1:0]          r_status;

    // Latched token and working values.
    logic                r_is_op;
    logic [1:0]          r_unit;
    logic [1:0]          r_op;
    logic                r_last;
    t_word               r_val;
    t_word               r_a;
    t_word               r_b;
    t_word               r_res;
    t_wide               r_prod;

    logic                in_xfer;
    logic                out_free;
    logic [REF_W-1:0]    scale_ref;
    t_word               mul_a;
    t_word               mul_b;
    t_wide               prod;
    t_wide               prod_adj;
    t_wide               addsub;
    t_div_req            div_req;
    logic                div_done;
    t_word               div_quot;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [SP_W-1:0]     sp_m1;
    logic [SP_W-1:0]     sp_m2;
    t_word               ram_rdata;

    // Result shaping for the last token.
    logic [IP_W-1:0]     top_x;
    logic [IP_W-1:0]     top_mag;
    logic [IP_W-1:0]     top_ip;
    logic signed [RESULT_W-1:0] top_int;
    logic [1:0]          fin_status;

    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;
    assign o_status    = r_status;

    // The one multiplier serves unit scaling and the multiply operator.
    assign scale_ref = (r_unit == UNIT_EM) ? r_em_ref : r_pct_ref;
    assign mul_a     = (r_state == S_SCALE) ? r_val : r_a;
    assign mul_b     = (r_state == S_SCALE) ? t_word'({{(DATA_W-REF_W){1'b0}}, scale_ref})
                                            : r_b;
    assign prod      = mul_a * mul_b;
    // Arithmetic shift of the product rounds toward minus infinity.
    assign prod_adj  = r_is_op ? (r_prod >>> FRAC_BITS) : r_prod;
    assign addsub    = (r_op == OP_SUB) ? (t_wide'(r_a) - t_wide'(r_b))
                                        : (t_wide'(r_a) + t_wide'(r_b));

    assign div_req.start    = (r_state == S_OPER) && (r_op == OP_DIV) && (r_b != '0);
    assign div_req.dividend = r_a;
    assign div_req.divisor  = r_b;

    assign sp_m1     = r_sp - 1'b1;
    assign sp_m2     = r_sp - 2'd2;
    assign ram_we    = (r_state == S_PUSH) && (r_sp < SP_W'(STACK_DEPTH));
    assign ram_waddr = r_sp[ADDR_W-1:0];
    // The top is addressed first so that it lands in r_b, then the entry below it for r_a.
    assign ram_raddr = (r_state == S_RDA) ? sp_m2[ADDR_W-1:0] : sp_m1[ADDR_W-1:0];

    // Integer part truncated toward zero, clamped to the result range.
    assign top_x   = {ram_rdata[DATA_W-1], ram_rdata};
    assign top_mag = ram_rdata[DATA_W-1] ? (-top_x) : top_x;
    assign top_ip  = top_mag >> FRAC_BITS;
    always_comb begin
        if (r_sp == '0) begin
            top_int = '0;
        end else if (!ram_rdata[DATA_W-1]) begin
            top_int = (top_ip > IP_W'(2**(RESULT_W-1) - 1))
                    ? RESULT_W'(2**(RESULT_W-1) - 1) : RESULT_W'(top_ip);
        end else begin
            top_int = (top_ip > IP_W'(2**(RESULT_W-1)))
                    ? RESULT_W'(2**(RESULT_W-1)) : RESULT_W'(-top_ip);
        end
    end
    assign fin_status = (r_sp == '0) ? keep_first(r_err, ST_UNDERFLOW) : r_err;

    pue_stack_ram u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (r_res),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    pue_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pct_ref <= '0;
            r_em_ref  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_PERCENT) begin
                r_pct_ref <= i_cfg_data;
            end else if (i_cfg_index == CFG_EM) begin
                r_em_ref <= i_cfg_data;
            end
        end
    end

    // Sequencer, stack pointer, error status and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            // In S_TOP the output register is handled by the state itself.
            if (r_out_valid && i_out_ready && r_state != S_TOP) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        if (i_kind == KIND_OPERAND) begin
                            if (i_unit == UNIT_PERCENT || i_unit == UNIT_EM) begin
                                r_state <= S_SCALE;
                            end else begin
                                r_state <= S_PUSH;
                            end
                        end else if (r_sp < SP_W'(2)) begin
                            // Too few values: the stack stays as it is.
                            r_err   <= keep_first(r_err, ST_UNDERFLOW);
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_RDB;
                        end
                    end
                end
                S_SCALE: r_state <= S_SAT;
                S_SAT:   r_state <= S_PUSH;
                S_PUSH: begin
                    if (r_sp < SP_W'(STACK_DEPTH)) begin
                        r_sp <= r_sp + 1'b1;
                    end else begin
                        r_err <= keep_first(r_err, ST_OVERFLOW);
                    end
                    r_state <= S_FIN;
                end
                S_RDB: r_state <= S_RDA;
                S_RDA: r_state <= S_OPA;
                S_OPA: r_state <= S_OPER;
                S_OPER: begin
                    r_sp <= sp_m2;
                    case (r_op)
                        OP_MUL:  r_state <= S_SAT;
                        OP_DIV: begin
                            if (r_b == '0) begin
                                r_err   <= keep_first(r_err, ST_DIVZERO);
                                r_state <= S_PUSH;
                            end else begin
                                r_state <= S_DIV;
                            end
                        end
                        default: r_state <= S_PUSH;
                    endcase
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_PUSH;
                    end
                end
                S_FIN: r_state <= r_last ? S_TOP : S_IDLE;
                S_TOP: begin
                    // Hold the read of the top until the output register is free.
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_sp        <= '0;
                        r_err       <= ST_OK;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_is_op <= i_kind;
            r_unit  <= i_unit;
            r_op    <= i_op;
            r_last  <= i_last;
            r_val   <= i_value;
            r_res   <= i_value;
        end
        if (r_state == S_SCALE || (r_state == S_OPER && r_op == OP_MUL)) begin
            r_prod <= prod;
        end
        if (r_state == S_SAT) begin
            r_res <= sat_word(prod_adj);
        end
        if (r_state == S_RDA) begin
            r_b <= ram_rdata;
        end
        if (r_state == S_OPA) begin
            r_a <= ram_rdata;
        end
        if (r_state == S_OPER) begin
            if (r_op == OP_DIV) begin
                r_res <= '0;
            end else begin
                r_res <= sat_word(addsub);
            end
        end
        if (r_state == S_DIV && div_done) begin
            r_res <= div_quot;
        end
        if (r_state == S_TOP && out_free) begin
            r_result <= top_int;
            r_status <= fin_status;
        end
    end

endmodule

@@ hw/rtl/pue_checker.sv @@
// Port-level checks of the postfix unit expression evaluator over time.
// Depends only on the top level's ports; bound to the top level at the end of this file.
module pue_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [15:0] o_result,
    input logic [1:0]  o_status
);

    // A result waiting on the receiver holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_result) && $stable(o_status))
        else $error("result changed or vanished while stalled");

    // The block is busy in the cycle after each accepted token.
    a_busy_after_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("token accepted back to back");

    // A result appears only at the end of a token's work.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared without work in progress");

    // Reset leaves the block empty and ready.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not idle after reset");

endmodule

bind postfix_unit_expression_evaluator_core pue_checker u_pue_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_result    (o_result),
    .o_status    (o_status)
);
